[hw/rtl/lsme_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsme_pkg
// shared types and constants of the lsb message extractor
// ----------------------------------------------------------------------------
package lsme_pkg;

  // results one carrier byte can cause (a full held prefix)
  localparam int MAX_RESULTS = 4;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

  // result queue: one full batch plus one waiting result
  localparam int QUEUE_DEPTH = MAX_RESULTS + 1;

  localparam int TAG_LENGTH_DEF = 4;

  localparam logic [7:0]  HEADER_LENGTH_RST = 8'd54;
  localparam logic [31:0] TAG_WORD_RST      = 32'h424D503A;  // "BMP:"

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_LENGTH = 2'd0,
    CFG_TAG_WORD      = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] carrier_byte;
    logic       first_of_file;
    logic       last_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] message_char;
    logic       char_present;
    logic       message_end;
  } out_item_t;

  // results of one carrier byte, item[0] goes out first
  typedef struct packed {
    out_item_t [MAX_RESULTS-1:0] item;
    logic [RES_CNT_W-1:0]        count;
  } batch_t;

endpackage

[hw/rtl/lsme_extract.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsme_extract
// bit gathering, tag prefix handling and message end for one carrier byte
// ----------------------------------------------------------------------------
module lsme_extract #(
  parameter int TAG_LENGTH = lsme_pkg::TAG_LENGTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  lsme_pkg::in_item_t item,
  input  logic [7:0]         header_length,
  input  logic [31:0]        tag_word,
  output lsme_pkg::batch_t   batch
);

  localparam int HC_W = $clog2(TAG_LENGTH + 1);
  localparam int RC_W = lsme_pkg::RES_CNT_W;

  logic [7:0]      hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]      acc_r, acc_nxt;
  logic [2:0]      pos_r, pos_nxt;
  logic [HC_W-1:0] hcnt_r, hcnt_nxt;
  logic            pd_r, pd_nxt;
  logic            fin_r, fin_nxt;
  logic [7:0]      held_r   [TAG_LENGTH];
  logic [7:0]      held_nxt [TAG_LENGTH];

  // state as seen after a possible restart
  logic [7:0]      hdr_e, acc_e;
  logic [2:0]      pos_e;
  logic [HC_W-1:0] hcnt_e;
  logic            pd_e, fin_e;

  logic [7:0]      acc_new, ch;
  logic            char_done, zero_char, store, single, decide, match;
  logic            flush, finish;
  logic [HC_W-1:0] cnt_after;
  logic [RC_W-1:0] n;

  always_comb begin
    hdr_e  = item.first_of_file ? '0 : hdr_cnt_r;
    acc_e  = item.first_of_file ? '0 : acc_r;
    pos_e  = item.first_of_file ? '0 : pos_r;
    hcnt_e = item.first_of_file ? '0 : hcnt_r;
    pd_e   = item.first_of_file ? 1'b0 : pd_r;
    fin_e  = item.first_of_file ? 1'b0 : fin_r;

    hdr_cnt_nxt = hdr_e;
    acc_nxt     = acc_e;
    pos_nxt     = pos_e;
    hcnt_nxt    = hcnt_e;
    pd_nxt      = pd_e;
    fin_nxt     = fin_e;
    held_nxt    = held_r;

    acc_new   = acc_e | ({7'd0, item.carrier_byte[0]} << pos_e);
    ch        = acc_new;
    char_done = 1'b0;
    zero_char = 1'b0;
    store     = 1'b0;
    single    = 1'b0;
    decide    = 1'b0;
    match     = 1'b1;
    flush     = 1'b0;
    finish    = 1'b0;
    cnt_after = hcnt_e;
    n         = '0;
    batch     = '0;

    if (!fin_e) begin
      if (hdr_e < header_length) begin
        hdr_cnt_nxt = hdr_e + 8'd1;
      end else if (pos_e == 3'd7) begin
        char_done = 1'b1;
        acc_nxt   = '0;
        pos_nxt   = '0;
      end else begin
        acc_nxt = acc_new;
        pos_nxt = pos_e + 3'd1;
      end

      zero_char = char_done && (ch == 8'd0);
      store     = char_done && (ch != 8'd0) && !pd_e;
      single    = char_done && (ch != 8'd0) && pd_e;

      for (int k = 0; k < TAG_LENGTH; k++) begin
        if (store && hcnt_e == HC_W'(k)) begin
          held_nxt[k] = ch;
        end
      end
      cnt_after = hcnt_e + HC_W'(store);
      decide    = store && (cnt_after == HC_W'(TAG_LENGTH));

      for (int i = 0; i < TAG_LENGTH; i++) begin
        if (held_nxt[i] != tag_word[31 - 8 * i -: 8]) begin
          match = 1'b0;
        end
      end

      // held prefix goes out on a zero char, a mismatch, or file end
      flush  = (zero_char && !pd_e) || (decide && !match) ||
               (item.last_of_file && !zero_char && !(pd_e || decide));
      finish = zero_char || item.last_of_file;

      pd_nxt   = pd_e || decide;
      hcnt_nxt = (decide || flush) ? '0 : cnt_after;
      fin_nxt  = finish;

      if (flush) begin
        for (int k = 0; k < TAG_LENGTH; k++) begin
          if (HC_W'(k) < cnt_after) begin
            batch.item[k].message_char = held_nxt[k];
            batch.item[k].char_present = 1'b1;
          end
        end
        n = RC_W'(cnt_after);
      end else if (single) begin
        batch.item[0].message_char = ch;
        batch.item[0].char_present = 1'b1;
        n = RC_W'(1);
      end

      if (finish) begin
        if (n == '0) begin
          // bare end marker
          batch.item[0].message_end = 1'b1;
          n = RC_W'(1);
        end else begin
          for (int k = 0; k < lsme_pkg::MAX_RESULTS; k++) begin
            if (RC_W'(k) == n - RC_W'(1)) begin
              batch.item[k].message_end = 1'b1;
            end
          end
        end
      end
    end
    batch.count = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r <= '0;
      acc_r     <= '0;
      pos_r     <= '0;
      hcnt_r    <= '0;
      pd_r      <= 1'b0;
      fin_r     <= 1'b0;
    end else if (accept) begin
      hdr_cnt_r <= hdr_cnt_nxt;
      acc_r     <= acc_nxt;
      pos_r     <= pos_nxt;
      hcnt_r    <= hcnt_nxt;
      pd_r      <= pd_nxt;
      fin_r     <= fin_nxt;
    end
  end

  // held prefix store, only read where written this message
  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

endmodule

[hw/rtl/lsme_result_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsme_result_queue
// shifting result queue, takes a batch of results and sends one per transfer
// ----------------------------------------------------------------------------
module lsme_result_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lsme_pkg::batch_t    batch,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output lsme_pkg::out_item_t out_data
);

  localparam int DEPTH = lsme_pkg::QUEUE_DEPTH;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IW    = lsme_pkg::RES_IDX_W;

  lsme_pkg::out_item_t slot_r   [DEPTH];
  lsme_pkg::out_item_t slot_nxt [DEPTH];
  lsme_pkg::out_item_t shifted  [DEPTH];
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    base, push_n;
  logic                pop;
  int                  rel;

  assign out_valid = (cnt_r != '0);
  assign out_data  = slot_r[0];
  // room for a whole batch
  assign in_ready  = (cnt_r <= CNT_W'(DEPTH - lsme_pkg::MAX_RESULTS));

  always_comb begin
    rel    = 0;
    pop    = out_valid && out_ready;
    base   = cnt_r - CNT_W'(pop);
    push_n = push ? CNT_W'(batch.count) : '0;

    for (int j = 0; j < DEPTH - 1; j++) begin
      shifted[j] = pop ? slot_r[j + 1] : slot_r[j];
    end
    shifted[DEPTH-1] = slot_r[DEPTH-1];

    for (int j = 0; j < DEPTH; j++) begin
      rel = j - int'(base);
      if (rel >= 0 && rel < int'(push_n)) begin
        slot_nxt[j] = batch.item[rel[IW-1:0]];
      end else begin
        slot_nxt[j] = shifted[j];
      end
    end
    cnt_nxt = base + push_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

[hw/rtl/lsb_stego_message_extract.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_stego_message_extract
// pulls a hidden text message out of the low bits of a carrier byte stream
// ----------------------------------------------------------------------------
// usage
//   in_*   : one carrier byte per transfer, with first/last of file flags;
//            first_of_file restarts all extraction state
//   out_*  : message characters, one per transfer; message_end marks the
//            last result of a message, char_present = 0 for a bare end marker
//   cfg_*  : register writes (header length, tag word), always ready; write
//            only while no results are pending
// results: the results of a byte are registered into the result queue on its transfer
// throughput: one byte per cycle while each byte yields at most one result;
//   a byte that releases the held prefix yields up to four results, and
//   in_ready drops until the result queue is back to one entry or fewer
// stalls: a waiting result sits in a five-entry result queue, so one more
//   byte is still taken while out_ready is low; beyond that in_ready drops
// reset: header length 54, tag word "BMP:", queue empty, state as a fresh file
// ----------------------------------------------------------------------------
module lsb_stego_message_extract #(
  parameter int TAG_LENGTH = lsme_pkg::TAG_LENGTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lsme_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lsme_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lsme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);

  logic             in_xfer;
  logic [7:0]       header_length_r;
  logic [31:0]      tag_word_r;
  lsme_pkg::batch_t batch;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_length_r <= lsme_pkg::HEADER_LENGTH_RST;
      tag_word_r      <= lsme_pkg::TAG_WORD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsme_pkg::CFG_HEADER_LENGTH: header_length_r <= cfg_data[7:0];
        lsme_pkg::CFG_TAG_WORD:      tag_word_r      <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // per-byte extraction, results of the byte form one batch
  lsme_extract #(
    .TAG_LENGTH(TAG_LENGTH)
  ) u_extract (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_xfer),
    .item         (in_data),
    .header_length(header_length_r),
    .tag_word     (tag_word_r),
    .batch        (batch)
  );

  // batch enters the queue on the byte transfer, drains one per out transfer
  lsme_result_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_xfer),
    .batch    (batch),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
